### src/chunk_reassembly_tracker_macros.svh
// assertion helpers shared by the tracker modules
// both expect a clock named clk and an active high reset named rst in scope
`ifndef CHUNK_REASSEMBLY_TRACKER_MACROS_SVH
`define CHUNK_REASSEMBLY_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define CRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CRT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define CRT_ASSERT(lbl, prop, msg)
`define CRT_NEVER(lbl, cond, msg)

`endif

`endif

### src/crt_pkg.sv
package crt_pkg;

  // default bitmap size in chunks
  localparam int MAX_CHUNKS_DEF = 4096;

  // fixed frame layout
  localparam int DOT11_BYTES  = 24;
  localparam int RADIOTAP_MIN = 12;

  // width of the lost chunk count on the result
  localparam int LOST_W = 13;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [47:0] SENDER_ADDRESS_RST = 48'h54C9FF02E8BC;
  localparam logic [7:0]  HEADER_BYTES_RST   = 8'd16;
  localparam logic [15:0] PAYLOAD_LIMIT_RST  = 16'd1400;
  localparam logic [7:0]  ACK_FLAG_MASK_RST  = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENDER_ADDRESS = 2'd0,
    REG_HEADER_BYTES   = 2'd1,
    REG_PAYLOAD_LIMIT  = 2'd2,
    REG_ACK_FLAG_MASK  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    STATUS_SHORT        = 4'd0,
    STATUS_WRONG_SOURCE = 4'd1,
    STATUS_BAD_MAGIC    = 4'd2,
    STATUS_BAD_NUMBER   = 4'd3,
    STATUS_HDR_MISMATCH = 4'd4,
    STATUS_PAYLOAD_BIG  = 4'd5,
    STATUS_EMPTY        = 4'd6,
    STATUS_TOO_MANY     = 4'd7,
    STATUS_ACCEPTED     = 4'd8,
    STATUS_DUPLICATE    = 4'd9
  } status_t;

  typedef struct packed {
    logic [47:0] sender_address;
    logic [7:0]  header_bytes;
    logic [15:0] payload_limit;
    logic [7:0]  ack_flag_mask;
  } cfg_t;

  typedef struct packed {
    logic [15:0] capture_length;
    logic [15:0] radiotap_length;
    logic [47:0] source_address;
    logic        magic_ok;
    logic [31:0] frame_number;
    logic [15:0] chunk_index;
    logic [15:0] chunk_total;
    logic [15:0] header_size_field;
    logic [15:0] payload_size_field;
    logic [7:0]  packet_flags;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               ack_request;
    logic [15:0]        store_length;
    logic               abandoned;
    logic [LOST_W-1:0]  lost_chunks;
    logic               resynced;
    logic               frame_done;
    logic [7:0]         done_flags;
  } out_item_t;

  // header check verdict
  typedef struct packed {
    status_t     status;
    logic        pass;
    logic        ack;
    logic [15:0] len;
  } chk_t;

  // bitmap update for the transaction leaving the stage register
  typedef struct packed {
    logic wr;
    logic clear;
  } bm_op_t;

endpackage

### src/crt_check.sv
module crt_check #(
  parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
  input  crt_pkg::cfg_t     cfg,
  input  crt_pkg::in_item_t item,
  output crt_pkg::chk_t     chk
);

  localparam logic [16:0] MAX_C = 17'(MAX_CHUNKS);

  logic [17:0] cap_w;
  logic [17:0] need_min;
  logic [17:0] need_rt;
  logic        short_cap;
  logic [15:0] avail;
  logic [15:0] len;

  // capture length against the fixed and radiotap dependent minimum
  assign cap_w     = 18'(item.capture_length);
  assign need_min  = 18'(crt_pkg::RADIOTAP_MIN + crt_pkg::DOT11_BYTES)
                     + 18'(cfg.header_bytes);
  assign need_rt   = 18'(item.radiotap_length) + 18'(crt_pkg::DOT11_BYTES)
                     + 18'(cfg.header_bytes);
  assign short_cap = (cap_w < need_min) || (cap_w < need_rt);

  // bytes left after all headers, only meaningful when not short
  assign avail = 16'(cap_w - need_rt);
  assign len   = (item.payload_size_field < avail) ? item.payload_size_field : avail;

  // checks in priority order
  always_comb begin
    chk        = '0;
    chk.status = crt_pkg::STATUS_SHORT;
    chk.len    = len;
    if (short_cap) begin
      chk.status = crt_pkg::STATUS_SHORT;
    end else if (item.source_address != cfg.sender_address) begin
      chk.status = crt_pkg::STATUS_WRONG_SOURCE;
    end else if (!item.magic_ok) begin
      chk.status = crt_pkg::STATUS_BAD_MAGIC;
    end else if (item.chunk_total == '0 || item.chunk_index >= item.chunk_total) begin
      chk.status = crt_pkg::STATUS_BAD_NUMBER;
    end else if (item.header_size_field != 16'(cfg.header_bytes)) begin
      chk.status = crt_pkg::STATUS_HDR_MISMATCH;
    end else if (item.payload_size_field > cfg.payload_limit) begin
      chk.status = crt_pkg::STATUS_PAYLOAD_BIG;
    end else if (len == '0) begin
      chk.status = crt_pkg::STATUS_EMPTY;
    end else begin
      chk.ack = (item.packet_flags & cfg.ack_flag_mask) != '0;
      if (17'(item.chunk_total) > MAX_C) begin
        chk.status = crt_pkg::STATUS_TOO_MANY;
      end else begin
        chk.status = crt_pkg::STATUS_ACCEPTED;
        chk.pass   = 1'b1;
      end
    end
  end

endmodule

### src/crt_bitmap.sv
`include "chunk_reassembly_tracker_macros.svh"

module crt_bitmap #(
  parameter int ROW_LOG = 6,
  parameter int ROW_AW  = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [ROW_AW-1:0]      rd_row,
  input  crt_pkg::bm_op_t        op,
  input  logic [(1<<ROW_LOG)-1:0] wr_data,
  output logic [(1<<ROW_LOG)-1:0] row_data
);

  localparam int ROW_BITS = 1 << ROW_LOG;
  localparam int DEPTH    = 1 << ROW_AW;

  logic [ROW_BITS-1:0] mem [DEPTH];
  logic [ROW_BITS-1:0] mem_q;
  logic [ROW_AW-1:0]   q_row;
  logic [DEPTH-1:0]    row_ok;
  logic [DEPTH-1:0]    row_ok_next;
  logic                fwd_ok;
  logic [ROW_AW-1:0]   fwd_row;
  logic [ROW_BITS-1:0] fwd_data;

  // row storage, written back for the row read one transaction earlier
  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[q_row] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_row];
      q_row <= rd_row;
    end
  end

  // per row valid bits, a clear empties the whole bitmap at once
  always_comb begin
    row_ok_next = op.clear ? '0 : row_ok;
    if (op.wr) begin
      row_ok_next[q_row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
    end else begin
      row_ok <= row_ok_next;
    end
  end

  // last written row, covers a read issued on the same edge as the write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_ok <= 1'b0;
    end else if (op.wr || op.clear) begin
      fwd_ok <= op.wr;
    end
    if (op.wr) begin
      fwd_row  <= q_row;
      fwd_data <= wr_data;
    end
  end

  // current contents of the row held for the stage register
  assign row_data = (fwd_ok && fwd_row == q_row) ? fwd_data :
                    (row_ok[q_row] ? mem_q : '0);

  `CRT_ASSERT(bm_clear_empties, op.clear && !op.wr |=> row_ok == '0 && !fwd_ok, "bitmap not empty after clear")
  `CRT_NEVER(bm_fwd_row_invalid, fwd_ok && !row_ok[fwd_row], "forwarded row has no valid bit")

endmodule

### src/chunk_reassembly_tracker.sv
// Chunk reassembly tracker: validates the header fields of each received chunk and tracks
// which chunks of the current frame have arrived. One input transaction gives one result
// transaction. The block takes one transaction per cycle; a result passes through a stage
// register holding the item while the bitmap row is read and then the result register, and
// only a full result register that is not taken holds the input side. The received-chunk
// bitmap is a memory of MAX_CHUNKS bits in rows of at least 64 bits, updated by one row
// read-modify-write per transaction with the last written row forwarded; a valid bit per
// row makes a frame restart or completion clear it at once, so no clearing pass is needed
// after reset. Configuration writes take effect at once and are meant for idle periods.
`include "chunk_reassembly_tracker_macros.svh"

module chunk_reassembly_tracker #(
  parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  crt_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output crt_pkg::out_item_t                out_data
);

  localparam int IDX_LOG  = $clog2(MAX_CHUNKS);
  localparam int ROW_LOG  = (IDX_LOG > 14) ? IDX_LOG - 8 : 6;
  localparam int ROW_BITS = 1 << ROW_LOG;
  localparam int NUM_ROWS = (MAX_CHUNKS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CNT_W    = $clog2(MAX_CHUNKS + 1);

  crt_pkg::cfg_t      cfg;
  logic               s1_valid;
  crt_pkg::in_item_t  s1_item;
  logic               advance;
  logic               in_acc;
  crt_pkg::chk_t      chk;
  crt_pkg::bm_op_t    op;
  crt_pkg::out_item_t res;

  logic               active;
  logic [31:0]        cur_frame;
  logic [CNT_W-1:0]   exp_cnt;
  logic [7:0]         fflags;
  logic [CNT_W-1:0]   rec_cnt;

  logic [ROW_BITS-1:0] bm_row;
  logic [ROW_BITS-1:0] base_row;
  logic [ROW_BITS-1:0] new_row;
  logic [ROW_LOG-1:0]  bit_sel;
  logic                restart;
  logic                aband;
  logic                resync;
  logic                cleared;
  logic                seen;
  logic                done;
  logic                upd;
  logic [CNT_W-1:0]    tot_c;
  logic [CNT_W-1:0]    lost_cnt;
  logic [CNT_W-1:0]    rec_base;
  logic [CNT_W-1:0]    rec_next;
  logic [CNT_W-1:0]    exp_next;
  logic [7:0]          flags_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sender_address <= crt_pkg::SENDER_ADDRESS_RST;
      cfg.header_bytes   <= crt_pkg::HEADER_BYTES_RST;
      cfg.payload_limit  <= crt_pkg::PAYLOAD_LIMIT_RST;
      cfg.ack_flag_mask  <= crt_pkg::ACK_FLAG_MASK_RST;
    end else if (cfg_we) begin
      case (crt_pkg::reg_idx_t'(cfg_index))
        crt_pkg::REG_SENDER_ADDRESS: cfg.sender_address <= cfg_data[47:0];
        crt_pkg::REG_HEADER_BYTES:   cfg.header_bytes   <= cfg_data[7:0];
        crt_pkg::REG_PAYLOAD_LIMIT:  cfg.payload_limit  <= cfg_data[15:0];
        crt_pkg::REG_ACK_FLAG_MASK:  cfg.ack_flag_mask  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline handshake
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_acc   = in_valid && in_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_acc) begin
      s1_item <= in_data;
    end
  end

  // header checks
  crt_check #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_check (
    .cfg  (cfg),
    .item (s1_item),
    .chk  (chk)
  );

  // received chunk bitmap
  crt_bitmap #(
    .ROW_LOG (ROW_LOG),
    .ROW_AW  (ROW_AW)
  ) u_bitmap (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_acc),
    .rd_row   (ROW_AW'(in_data.chunk_index >> ROW_LOG)),
    .op       (op),
    .wr_data  (new_row),
    .row_data (bm_row)
  );

  // assembly tracking for the transaction in the stage register
  always_comb begin
    bit_sel   = s1_item.chunk_index[ROW_LOG-1:0];
    tot_c     = CNT_W'(s1_item.chunk_total);
    restart   = !active || (s1_item.frame_number != cur_frame);
    aband     = restart && active && (rec_cnt < exp_cnt);
    lost_cnt  = exp_cnt - rec_cnt;
    resync    = !restart && (tot_c != exp_cnt);
    cleared   = restart || resync;
    base_row  = cleared ? '0 : bm_row;
    seen      = base_row[bit_sel];
    new_row   = base_row;
    new_row[bit_sel] = 1'b1;
    rec_base  = cleared ? '0 : rec_cnt;
    exp_next  = cleared ? tot_c : exp_cnt;
    rec_next  = seen ? rec_base : rec_base + CNT_W'(1);
    done      = (rec_next == exp_next);
    flags_eff = cleared ? s1_item.packet_flags : fflags;
    upd       = advance && chk.pass;
    op.wr     = upd && !done && !seen;
    op.clear  = upd && (cleared || done);
  end

  // assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cur_frame <= '0;
      exp_cnt   <= '0;
      fflags    <= '0;
      rec_cnt   <= '0;
    end else if (upd) begin
      if (cleared) begin
        cur_frame <= s1_item.frame_number;
        fflags    <= s1_item.packet_flags;
      end
      if (done) begin
        active  <= 1'b0;
        exp_cnt <= '0;
        rec_cnt <= '0;
      end else begin
        active  <= 1'b1;
        exp_cnt <= exp_next;
        rec_cnt <= rec_next;
      end
    end
  end

  // result fields
  always_comb begin
    res             = '0;
    res.status      = chk.status;
    res.ack_request = chk.ack;
    if (chk.pass) begin
      res.status       = seen ? crt_pkg::STATUS_DUPLICATE : crt_pkg::STATUS_ACCEPTED;
      res.store_length = seen ? '0 : chk.len;
      res.abandoned    = aband;
      res.lost_chunks  = aband ? crt_pkg::LOST_W'(lost_cnt) : '0;
      res.resynced     = resync;
      res.frame_done   = done;
      res.done_flags   = done ? flags_eff : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= res;
    end
  end

  `CRT_ASSERT(idle_counts_zero, !active |-> rec_cnt == '0 && exp_cnt == '0, "idle assembly holds counts")
  `CRT_ASSERT(active_count_below, active |-> rec_cnt < exp_cnt, "active assembly already complete")
  `CRT_ASSERT(done_only_tracked, out_valid && out_data.frame_done |-> out_data.status == crt_pkg::STATUS_ACCEPTED || out_data.status == crt_pkg::STATUS_DUPLICATE, "completion on rejected chunk")
  `CRT_NEVER(store_without_accept, out_valid && out_data.store_length != '0 && out_data.status != crt_pkg::STATUS_ACCEPTED, "store length on chunk not accepted")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int PRINT_CAP    = 40;

  // ways to spoil an otherwise good chunk header
  typedef enum int {
    FAULT_SHORT,
    FAULT_SOURCE,
    FAULT_MAGIC,
    FAULT_NUMBERING,
    FAULT_HEADER,
    FAULT_PAYLOAD,
    FAULT_EMPTY,
    FAULT_TOO_MANY
  } fault_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [crt_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  crt_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  crt_pkg::out_item_t             out_data;

  chunk_reassembly_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // register copies
  logic [47:0] cfg_sender    = crt_pkg::SENDER_ADDRESS_RST;
  logic [7:0]  cfg_hdr_bytes = crt_pkg::HEADER_BYTES_RST;
  logic [15:0] cfg_pay_limit = crt_pkg::PAYLOAD_LIMIT_RST;
  logic [7:0]  cfg_ack_mask  = crt_pkg::ACK_FLAG_MASK_RST;

  // assembly state of the tracker
  logic        asm_active      = 1'b0;
  logic [31:0] cur_frame       = '0;
  int          chunks_expected = 0;
  int          chunks_received = 0;
  logic [7:0]  cur_flags       = '0;
  bit          seen_chunks[int];

  crt_pkg::out_item_t chunk_verdicts[$];
  int          mismatch_count = 0;
  int          headers_sent   = 0;
  int          cycle_count    = 0;
  int          hold_cycles    = 0;
  bit          idle_on        = 1'b1;
  logic [31:0] last_frame     = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // restart the bitmap for a new frame
  function automatic void start_frame(input logic [31:0] frame, input int total,
                                      input logic [7:0] flags);
    asm_active      = 1'b1;
    cur_frame       = frame;
    chunks_expected = total;
    cur_flags       = flags;
    chunks_received = 0;
    seen_chunks.delete();
  endfunction

  // expected verdict for one header, advances the assembly state
  function automatic crt_pkg::out_item_t track_chunk(input crt_pkg::in_item_t it);
    crt_pkg::out_item_t r;
    int cap, rt, hdr, avail, len, idx, total;
    r     = '0;
    cap   = int'(it.capture_length);
    rt    = int'(it.radiotap_length);
    hdr   = int'(cfg_hdr_bytes);
    idx   = int'(it.chunk_index);
    total = int'(it.chunk_total);
    if (cap < crt_pkg::RADIOTAP_MIN + crt_pkg::DOT11_BYTES + hdr ||
        cap < rt + crt_pkg::DOT11_BYTES + hdr) begin
      r.status = crt_pkg::STATUS_SHORT;
    end else if (it.source_address != cfg_sender) begin
      r.status = crt_pkg::STATUS_WRONG_SOURCE;
    end else if (!it.magic_ok) begin
      r.status = crt_pkg::STATUS_BAD_MAGIC;
    end else if (total == 0 || idx >= total) begin
      r.status = crt_pkg::STATUS_BAD_NUMBER;
    end else if (it.header_size_field != 16'(cfg_hdr_bytes)) begin
      r.status = crt_pkg::STATUS_HDR_MISMATCH;
    end else if (it.payload_size_field > cfg_pay_limit) begin
      r.status = crt_pkg::STATUS_PAYLOAD_BIG;
    end else begin
      avail = cap - rt - crt_pkg::DOT11_BYTES - hdr;
      len   = (int'(it.payload_size_field) < avail) ? int'(it.payload_size_field) : avail;
      if (len == 0) begin
        r.status = crt_pkg::STATUS_EMPTY;
      end else begin
        r.ack_request = |(it.packet_flags & cfg_ack_mask);
        if (total > crt_pkg::MAX_CHUNKS_DEF) begin
          r.status = crt_pkg::STATUS_TOO_MANY;
        end else begin
          // new frame number drops whatever was in progress
          if (!asm_active || it.frame_number != cur_frame) begin
            if (asm_active && chunks_received < chunks_expected) begin
              r.abandoned   = 1'b1;
              r.lost_chunks = crt_pkg::LOST_W'(chunks_expected - chunks_received);
            end
            start_frame(it.frame_number, total, it.packet_flags);
          end
          // count mismatch on a running frame
          if (total != chunks_expected) begin
            r.resynced = 1'b1;
            start_frame(it.frame_number, total, it.packet_flags);
          end
          if (!seen_chunks.exists(idx)) begin
            seen_chunks[idx] = 1'b1;
            chunks_received++;
            r.status       = crt_pkg::STATUS_ACCEPTED;
            r.store_length = 16'(len);
          end else begin
            r.status = crt_pkg::STATUS_DUPLICATE;
          end
          // all chunks in
          if (chunks_received == chunks_expected) begin
            r.frame_done    = 1'b1;
            r.done_flags    = cur_flags;
            asm_active      = 1'b0;
            chunks_received = 0;
            chunks_expected = 0;
            seen_chunks.delete();
          end
        end
      end
    end
    return r;
  endfunction

  // chunk for the current settings, well-formed but for an occasional zero payload size
  function automatic crt_pkg::in_item_t make_chunk(input logic [31:0] frame, input int idx,
                                                   input int total, input logic [7:0] flags);
    crt_pkg::in_item_t it;
    int rt, base, extra;
    rt   = $urandom_range(0, 80);
    base = ((rt > crt_pkg::RADIOTAP_MIN) ? rt : crt_pkg::RADIOTAP_MIN)
           + crt_pkg::DOT11_BYTES + int'(cfg_hdr_bytes);
    if ($urandom_range(0, 9) == 0) begin
      extra = $urandom_range(0, 65535 - base);
    end else begin
      extra = $urandom_range(0, 1500);
    end
    it.capture_length    = 16'(base + extra);
    it.radiotap_length   = 16'(rt);
    it.source_address    = cfg_sender;
    it.magic_ok          = 1'b1;
    it.frame_number      = frame;
    it.chunk_index       = 16'(idx);
    it.chunk_total       = 16'(total);
    it.header_size_field = 16'(cfg_hdr_bytes);
    if ($urandom_range(0, 9) == 0) begin
      it.payload_size_field = 16'($urandom_range(0, cfg_pay_limit));
    end else begin
      it.payload_size_field = 16'($urandom_range(1, cfg_pay_limit));
    end
    it.packet_flags = flags;
    return it;
  endfunction

  // spoil one check of a good chunk
  function automatic crt_pkg::in_item_t break_chunk(input crt_pkg::in_item_t it,
                                                    input fault_t fault);
    int hdr, rt, b;
    hdr = int'(cfg_hdr_bytes);
    rt  = int'(it.radiotap_length);
    b   = $urandom_range(0, 47);
    case (fault)
      FAULT_SHORT: begin
        if ($urandom_range(0, 1) == 0) begin
          it.capture_length = 16'($urandom_range(0, crt_pkg::RADIOTAP_MIN
                                                    + crt_pkg::DOT11_BYTES + hdr - 1));
        end else begin
          it.radiotap_length = 16'hFFFF;
        end
      end
      FAULT_SOURCE: it.source_address[b] = ~it.source_address[b];
      FAULT_MAGIC: it.magic_ok = 1'b0;
      FAULT_NUMBERING: begin
        if ($urandom_range(0, 3) == 0) begin
          it.chunk_total = '0;
        end else begin
          it.chunk_index = 16'($urandom_range(it.chunk_total, 65535));
        end
      end
      FAULT_HEADER: it.header_size_field = 16'(hdr) ^ (16'd1 << $urandom_range(0, 15));
      FAULT_PAYLOAD: begin
        if (cfg_pay_limit != 16'hFFFF) begin
          it.payload_size_field = 16'($urandom_range(int'(cfg_pay_limit) + 1, 65535));
        end else begin
          it.payload_size_field = '0;
        end
      end
      FAULT_EMPTY: begin
        if (rt >= crt_pkg::RADIOTAP_MIN && $urandom_range(0, 1) == 0) begin
          it.capture_length = 16'(rt + crt_pkg::DOT11_BYTES + hdr);
        end else begin
          it.payload_size_field = '0;
        end
      end
      FAULT_TOO_MANY: begin
        it.chunk_total = 16'($urandom_range(crt_pkg::MAX_CHUNKS_DEF + 1, 65535));
        it.chunk_index = 16'($urandom_range(0, int'(it.chunk_total) - 1));
      end
      default: ;
    endcase
    return it;
  endfunction

  // offer one header, called and returning at a falling edge
  task automatic send_item(input crt_pkg::in_item_t item);
    if (idle_on && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chunk_verdicts.push_back(track_chunk(item));
    headers_sent++;
    @(negedge clk);
  endtask

  // drain everything in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (chunk_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input crt_pkg::reg_idx_t idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      crt_pkg::REG_SENDER_ADDRESS: cfg_sender    = val;
      crt_pkg::REG_HEADER_BYTES:   cfg_hdr_bytes = val[7:0];
      crt_pkg::REG_PAYLOAD_LIMIT:  cfg_pay_limit = val[15:0];
      crt_pkg::REG_ACK_FLAG_MASK:  cfg_ack_mask  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [47:0] sender, input logic [7:0] hdr,
                                input logic [15:0] limit, input logic [7:0] mask);
    settle();
    write_reg(crt_pkg::REG_SENDER_ADDRESS, sender);
    write_reg(crt_pkg::REG_HEADER_BYTES, 48'(hdr));
    write_reg(crt_pkg::REG_PAYLOAD_LIMIT, 48'(limit));
    write_reg(crt_pkg::REG_ACK_FLAG_MASK, 48'(mask));
  endtask

  // one frame worth of chunks in random order, with noise mixed in
  task automatic random_frame();
    logic [31:0]       frame;
    logic [7:0]        flags;
    crt_pkg::in_item_t junk;
    int                total, pick, n, j, k, tmp, alt;
    int                order[$];
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      frame = last_frame;
    end else if (pick < 33) begin
      frame = '0;
    end else if (pick < 36) begin
      frame = '1;
    end else begin
      frame = $urandom;
    end
    last_frame = frame;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      total = $urandom_range(1, 8);
    end else if (pick < 90) begin
      total = $urandom_range(9, 40);
    end else if (pick < 96) begin
      total = $urandom_range(crt_pkg::MAX_CHUNKS_DEF - 8, crt_pkg::MAX_CHUNKS_DEF);
    end else begin
      total = $urandom_range(crt_pkg::MAX_CHUNKS_DEF + 1, 65535);
    end
    flags = 8'($urandom);
    if (total <= 40) begin
      for (j = 0; j < total; j++) order.push_back(j);
      for (j = total - 1; j > 0; j--) begin
        k        = $urandom_range(0, j);
        tmp      = order[j];
        order[j] = order[k];
        order[k] = tmp;
      end
    end else begin
      repeat ($urandom_range(1, 4)) order.push_back($urandom_range(0, total - 1));
      order.push_back(total - 1);
    end
    // sometimes stop early so the frame is abandoned
    n = ($urandom_range(0, 99) < 15) ? $urandom_range(1, order.size()) : order.size();
    for (j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(break_chunk(make_chunk(frame, order[j], total, flags),
                              fault_t'($urandom_range(0, FAULT_TOO_MANY))));
      end else if (pick < 14) begin
        junk.capture_length     = 16'($urandom);
        junk.radiotap_length    = 16'($urandom);
        junk.source_address     = {16'($urandom), $urandom};
        junk.magic_ok           = 1'($urandom);
        junk.frame_number       = $urandom;
        junk.chunk_index        = 16'($urandom);
        junk.chunk_total        = 16'($urandom);
        junk.header_size_field  = 16'($urandom);
        junk.payload_size_field = 16'($urandom);
        junk.packet_flags       = 8'($urandom);
        send_item(junk);
      end else if (pick < 18 && j > 0) begin
        send_item(make_chunk(frame, order[$urandom_range(0, j - 1)], total, flags));
      end else if (pick < 21) begin
        alt = $urandom_range(1, 8);
        send_item(make_chunk(frame, $urandom_range(0, alt - 1), alt, flags));
      end
      send_item(make_chunk(frame, order[j], total,
                           ($urandom_range(0, 99) < 20) ? 8'($urandom) : flags));
    end
  endtask

  // one of each rejection, plus all-zero and all-one headers
  task automatic test_rejects();
    for (int m = 0; m <= FAULT_TOO_MANY; m++) begin
      send_item(break_chunk(make_chunk(32'h1234, 0, 2, 8'h01), fault_t'(m)));
    end
    send_item('0);
    send_item('1);
  endtask

  // duplicate, abandon, resync, completion and restart of a finished frame
  task automatic test_assembly();
    send_item(make_chunk(32'h0, 2, 3, 8'h01));
    send_item(make_chunk(32'h0, 2, 3, 8'h01));
    send_item(make_chunk(32'h0, 0, 3, 8'h01));
    send_item(make_chunk(32'hFFFF_FFFF, 0, 2, 8'hFE));
    send_item(make_chunk(32'hFFFF_FFFF, 1, 3, 8'h7F));
    send_item(make_chunk(32'hFFFF_FFFF, 0, 3, 8'h00));
    send_item(make_chunk(32'hFFFF_FFFF, 2, 3, 8'h00));
    send_item(make_chunk(32'h7, 0, 1, 8'hA5));
    send_item(make_chunk(32'h7, 0, 1, 8'h5A));
    send_item(make_chunk(32'h9, crt_pkg::MAX_CHUNKS_DEF - 1, crt_pkg::MAX_CHUNKS_DEF, 8'h00));
    send_item(make_chunk(32'hA, 0, 1, 8'h01));
  endtask

  // register extremes
  task automatic test_config_extremes();
    crt_pkg::in_item_t it;
    apply_settings(48'h0, 8'd255, 16'hFFFF, 8'hFF);
    it = make_chunk(32'h55, 0, 2, 8'h80);
    it.capture_length     = 16'hFFFF;
    it.payload_size_field = 16'hFFFF;
    send_item(it);
    it.source_address = '1;
    send_item(it);
    apply_settings('1, 8'd1, 16'd1, 8'h00);
    send_item(break_chunk(make_chunk(32'h55, 1, 2, 8'hFF), FAULT_PAYLOAD));
    send_item(make_chunk(32'h55, 1, 2, 8'hFF));
  endtask

  // receiver stalls long enough for the input side to back up
  task automatic test_backpressure();
    apply_settings(crt_pkg::SENDER_ADDRESS_RST, crt_pkg::HEADER_BYTES_RST,
                   crt_pkg::PAYLOAD_LIMIT_RST, crt_pkg::ACK_FLAG_MASK_RST);
    hold_cycles = 300;
    for (int k = 0; k < 30; k++) begin
      send_item(make_chunk(32'hC0DE, k, 30, 8'h3C));
    end
  endtask

  // random frames over several settings
  task automatic test_random();
    int target;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apply_settings({16'($urandom), $urandom}, 8'd1, 16'hFFFF, 8'hFF);
        1: apply_settings({16'($urandom), $urandom}, 8'd255, 16'd1, 8'h00);
        2: apply_settings(48'h0, 8'($urandom_range(1, 255)),
                          16'($urandom_range(1, 65535)), 8'($urandom));
        3: apply_settings('1, 8'($urandom_range(1, 255)),
                          16'($urandom_range(1, 3000)), 8'($urandom));
        default: apply_settings({16'($urandom), $urandom}, 8'($urandom_range(1, 64)),
                                16'($urandom_range(1, 65535)), 8'($urandom));
      endcase
      // one phase runs with no idling on either side
      idle_on = (phase != 2);
      if (phase == 3) hold_cycles = 200;
      target = headers_sent + RANDOM_ITEMS / 5;
      while (headers_sent < target) random_frame();
    end
    idle_on = 1'b1;
  endtask

  // receiver ready
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < 16);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    crt_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (chunk_verdicts.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = chunk_verdicts.pop_front();
        if (out_data.status != want.status)
          report_mismatch($sformatf("status got %0d exp %0d", out_data.status, want.status));
        if (out_data.ack_request != want.ack_request)
          report_mismatch($sformatf("ack_request got %0d exp %0d",
                                    out_data.ack_request, want.ack_request));
        if (out_data.store_length != want.store_length)
          report_mismatch($sformatf("store_length got %0d exp %0d",
                                    out_data.store_length, want.store_length));
        if (out_data.abandoned != want.abandoned)
          report_mismatch($sformatf("abandoned got %0d exp %0d",
                                    out_data.abandoned, want.abandoned));
        if (out_data.lost_chunks != want.lost_chunks)
          report_mismatch($sformatf("lost_chunks got %0d exp %0d",
                                    out_data.lost_chunks, want.lost_chunks));
        if (out_data.resynced != want.resynced)
          report_mismatch($sformatf("resynced got %0d exp %0d",
                                    out_data.resynced, want.resynced));
        if (out_data.frame_done != want.frame_done)
          report_mismatch($sformatf("frame_done got %0d exp %0d",
                                    out_data.frame_done, want.frame_done));
        if (out_data.done_flags != want.done_flags)
          report_mismatch($sformatf("done_flags got %0h exp %0h",
                                    out_data.done_flags, want.done_flags));
      end
    end
  end

  // test sequence
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = crt_pkg::REG_SENDER_ADDRESS;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_rejects();
    test_assembly();
    test_config_extremes();
    test_backpressure();
    test_random();
    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
